[hdl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
    } cmd_beat_t;

    typedef struct packed {
        logic [KEY_W-1:0]   removed_key;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
    } result_beat_t;

    // per-cycle operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctl_t;

endpackage

[hdl/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell #(
    parameter int KEY_BITS = 32,
    parameter int CW       = 5,
    parameter int IDX      = 0
) (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic [CW-1:0]       fill,
    input  logic [KEY_BITS-1:0] prev_key,
    input  logic                prev_gt,
    input  logic [KEY_BITS-1:0] next_key,
    output logic [KEY_BITS-1:0] key,
    output logic                gt
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                occ;
    logic                tail;

    assign occ  = CW'(IDX) < fill;
    assign tail = CW'(IDX) == fill;
    assign gt   = occ && (key_reg > new_key);
    assign key  = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins)
        begin
            if (prev_gt)
                key_next = prev_key;
            else if (gt || tail)
                key_next = new_key;
        end
        else if (ctl.rem)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

[hdl/sorted_insert_priority_queue.sv]
`timescale 1ns / 1ps

// Min priority queue held as a sorted row of DEPTH cells, smallest key in
// cell 0. On an insert every cell compares its key with the incoming key in
// parallel and takes its own, its lower neighbor's or the new key; on a remove
// every cell takes its upper neighbor's key. Busy stays low, one beat is
// taken per cycle, and its result beat appears with done high in the following
// cycle. The result must be captured in that cycle. Equal keys leave in
// arrival order. The capacity register may only be written while no command
// is in flight; values above DEPTH act as DEPTH and zero rejects every insert.
module sorted_insert_priority_queue #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  spq_pkg::cmd_beat_t                     cmd,
    output logic                                   done,
    output spq_pkg::result_beat_t                  result,
    input  logic                                   cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]              cfg_wdata
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;

    logic [spq_pkg::CAP_W-1:0] cap_reg;
    logic [CW-1:0]             fill_reg;
    logic [CW-1:0]             fill_next;
    logic                      done_reg;
    logic                      done_next;
    spq_pkg::result_beat_t     result_reg;
    spq_pkg::result_beat_t     result_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic [KEY_BITS-1:0]       new_key;
    spq_pkg::cell_ctl_t        ctl;

    logic [KEY_BITS-1:0]       cell_key [DEPTH];
    logic                      cell_gt  [DEPTH];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign new_key = KEY_BITS'(cmd.key);
    assign full    = (CMPW'(fill_reg) >= CMPW'(cap_reg)) || (fill_reg >= CW'(DEPTH));
    assign empty   = (fill_reg == '0);

    assign ctl.ins = accept && (cmd.kind == spq_pkg::KIND_INSERT) && !full;
    assign ctl.rem = accept && (cmd.kind == spq_pkg::KIND_REMOVE) && !empty;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_BITS-1:0] prev_key;
        logic                prev_gt;
        logic [KEY_BITS-1:0] next_key;

        if (i == 0)
        begin : g_first
            assign prev_key = '0;
            assign prev_gt  = 1'b0;
        end
        else
        begin : g_mid
            assign prev_key = cell_key[i-1];
            assign prev_gt  = cell_gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_key = '0;
        end
        else
        begin : g_inner
            assign next_key = cell_key[i+1];
        end

        spq_cell #(
            .KEY_BITS (KEY_BITS),
            .CW       (CW),
            .IDX      (i)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .new_key  (new_key),
            .fill     (fill_reg),
            .prev_key (prev_key),
            .prev_gt  (prev_gt),
            .next_key (next_key),
            .key      (cell_key[i]),
            .gt       (cell_gt[i])
        );
    end

    always_comb
    begin
        fill_next               = fill_reg;
        done_next               = accept;
        result_next             = result_reg;
        if (accept)
        begin
            result_next.removed_key = '0;
            result_next.status      = spq_pkg::STAT_DONE;
            if (cmd.kind == spq_pkg::KIND_INSERT)
            begin
                if (full)
                    result_next.status = spq_pkg::STAT_FULL;
                else
                    fill_next = CW'(fill_reg + 1'b1);
            end
            else
            begin
                if (empty)
                    result_next.status = spq_pkg::STAT_EMPTY;
                else
                begin
                    result_next.removed_key = spq_pkg::KEY_W'(cell_key[0]);
                    fill_next               = CW'(fill_reg - 1'b1);
                end
            end
            result_next.count = spq_pkg::COUNT_W'(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= spq_pkg::CAP_RESET;
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            fill_reg <= fill_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted beat without result");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.kind == spq_pkg::KIND_INSERT && full) |=> $stable(fill_reg))
        else $error("dropped insert changed fill");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == spq_pkg::STAT_EMPTY) |->
            (result.count == '0 && result.removed_key == '0))
        else $error("empty remove reported data");

    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rem |=> (fill_reg == CW'($past(fill_reg) - 1'b1)))
        else $error("remove did not shrink fill");

endmodule
